@@ rtl/core/tpwe_pkg.sv @@
`default_nettype none

package tpwe_pkg;

	localparam int CountW = 16;
	localparam int LenW   = 6;
	localparam int LevelW = 8;
	localparam int ByteW  = 8;
	localparam int CfgIdxW = 3;
	localparam int CfgW   = 8;
	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	typedef enum logic [2:0] {
		REQ_GAP   = 3'd0,
		REQ_TMARK = 3'd1,
		REQ_BYTE  = 3'd2,
		REQ_CSUM  = 3'd3,
		REQ_CLEAR = 3'd4
	} req_code_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_LONG_LOW   = 3'd0,
		CFG_LONG_HIGH  = 3'd1,
		CFG_SHORT_LOW  = 3'd2,
		CFG_SHORT_HIGH = 3'd3,
		CFG_LOW_LEVEL  = 3'd4,
		CFG_HIGH_LEVEL = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CMD_GAP   = 2'd0,
		CMD_TMARK = 2'd1,
		CMD_BYTE  = 2'd2,
		CMD_CSUM  = 2'd3
	} cmd_kind_t;

	// data holds the bits to send MSB-aligned; a single byte sits in the upper half
	typedef struct packed {
		cmd_kind_t           kind;
		logic [CountW-1:0]   count;
		logic [2*ByteW-1:0]  data;
	} cmd_t;

	typedef struct packed {
		logic [LenW-1:0]   long_low;
		logic [LenW-1:0]   long_high;
		logic [LenW-1:0]   short_low;
		logic [LenW-1:0]   short_high;
		logic [LevelW-1:0] low_level;
		logic [LevelW-1:0] high_level;
	} cfg_t;

	typedef struct packed {
		logic              pulse_long;
		logic [CountW-1:0] repeat_res;
		logic [LenW-1:0]   low_samples;
		logic [LenW-1:0]   high_samples;
		logic [LevelW-1:0] low_value;
		logic [LevelW-1:0] high_value;
		logic              last;
	} res_t;

	localparam logic [LenW-1:0]   LongLowRst   = 6'd21;
	localparam logic [LenW-1:0]   LongHighRst  = 6'd22;
	localparam logic [LenW-1:0]   ShortLowRst  = 6'd11;
	localparam logic [LenW-1:0]   ShortHighRst = 6'd12;
	localparam logic [LevelW-1:0] LowLevelRst  = 8'd32;
	localparam logic [LevelW-1:0] HighLevelRst = 8'd224;

	localparam logic [CountW-1:0] TmarkTailRep = 16'd2;

endpackage

`default_nettype wire

@@ rtl/core/tpwe_if.sv @@
`default_nettype none

interface tpwe_req_if import tpwe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        req_type;
	logic [CountW-1:0] count;
	logic [ByteW-1:0]  data_byte;

	modport source (output valid, req_type, count, data_byte, input ready);
	modport sink (input valid, req_type, count, data_byte, output ready);
endinterface

interface tpwe_res_if import tpwe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              pulse_long;
	logic [CountW-1:0] repeat_res;
	logic [LenW-1:0]   low_samples;
	logic [LenW-1:0]   high_samples;
	logic [LevelW-1:0] low_value;
	logic [LevelW-1:0] high_value;
	logic              last;

	modport source (output valid, pulse_long, repeat_res, low_samples, high_samples,
		low_value, high_value, last, input ready);
	modport sink (input valid, pulse_long, repeat_res, low_samples, high_samples,
		low_value, high_value, last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tpwe_front.sv @@
`default_nettype none

module tpwe_front import tpwe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	tpwe_req_if.sink  req,
	output logic      push_valid,
	input  wire logic push_ready,
	output cmd_t      push_cmd
);

	logic [CountW-1:0] csum_q;
	logic [3:0]        ones;
	logic              take;

	assign req.ready = push_ready;
	assign take      = req.valid && push_ready;

	always_comb begin
		ones = '0;
		for (int i = 0; i < ByteW; i++) begin
			ones = ones + {3'd0, req.data_byte[i]};
		end
	end

	always_comb begin
		push_valid     = 1'b0;
		push_cmd.kind  = CMD_GAP;
		push_cmd.count = req.count;
		push_cmd.data  = {req.data_byte, {ByteW{1'b0}}};
		case (req.req_type)
			REQ_GAP: begin
				push_valid = take && (req.count != '0);
			end
			REQ_TMARK: begin
				push_valid    = take;
				push_cmd.kind = CMD_TMARK;
			end
			REQ_BYTE: begin
				push_valid    = take;
				push_cmd.kind = CMD_BYTE;
			end
			REQ_CSUM: begin
				push_valid    = take;
				push_cmd.kind = CMD_CSUM;
				push_cmd.data = csum_q;
			end
			default: begin
				push_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csum_q <= '0;
		end else if (take) begin
			if (req.req_type == REQ_BYTE) begin
				csum_q <= csum_q + {12'd0, ones};
			end else if (req.req_type == REQ_CLEAR) begin
				csum_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/tpwe_fifo.sv @@
`default_nettype none

module tpwe_fifo import tpwe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire cmd_t push_cmd,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output cmd_t      pop_cmd
);

	cmd_t           mem_q [QDepth];
	logic [QAw-1:0] wptr_q;
	logic [QAw-1:0] rptr_q;
	logic [QAw:0]   cnt_q;
	logic           push;
	logic           pop;

	assign push_ready = (cnt_q != QDepth[QAw:0]);
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = mem_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QDepth[QAw:0])
		else $error("queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wptr_q - rptr_q) == cnt_q[QAw-1:0])
		else $error("queue pointers disagree with count");

	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a push");

endmodule

`default_nettype wire

@@ rtl/core/tpwe_back.sv @@
`default_nettype none

module tpwe_back import tpwe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic pop_valid,
	output logic      pop_ready,
	input  wire cmd_t pop_cmd,
	tpwe_res_if.source res
);

	cmd_t       cur_q;
	logic       busy_q;
	logic [1:0] tm_q;
	logic [3:0] bit_q;
	logic       byte_q;
	logic       tail_q;
	logic       res_valid_q;
	res_t       res_q;

	logic              adv;
	logic              is_long;
	logic [CountW-1:0] rep;
	logic              fin;
	res_t              res_d;

	always_comb begin
		is_long = 1'b1;
		rep     = 16'd1;
		fin     = 1'b0;
		case (cur_q.kind)
			CMD_GAP: begin
				is_long = 1'b0;
				rep     = cur_q.count;
				fin     = 1'b1;
			end
			CMD_TMARK: begin
				is_long = (tm_q != 2'd1);
				rep     = (tm_q == 2'd2) ? TmarkTailRep : cur_q.count;
				fin     = (tm_q == 2'd2);
			end
			default: begin
				if (tail_q) begin
					fin = 1'b1;
				end else if (bit_q == 4'd8) begin
					fin = (cur_q.kind == CMD_BYTE);
				end else begin
					is_long = cur_q.data[2*ByteW-1];
				end
			end
		endcase
	end

	always_comb begin
		res_d.pulse_long   = is_long;
		res_d.repeat_res   = rep;
		res_d.low_samples  = is_long ? cfg.long_low : cfg.short_low;
		res_d.high_samples = is_long ? cfg.long_high : cfg.short_high;
		res_d.low_value    = cfg.low_level;
		res_d.high_value   = cfg.high_level;
		res_d.last         = fin;
	end

	assign adv       = busy_q && (!res_valid_q || res.ready);
	assign pop_ready = !busy_q || (adv && fin);

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
			cur_q       <= '0;
			tm_q        <= '0;
			bit_q       <= '0;
			byte_q      <= 1'b0;
			tail_q      <= 1'b0;
		end else begin
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			if (pop_valid && pop_ready) begin
				busy_q <= 1'b1;
				cur_q  <= pop_cmd;
				tm_q   <= (pop_cmd.count == '0) ? 2'd2 : 2'd0;
				bit_q  <= '0;
				byte_q <= 1'b0;
				tail_q <= 1'b0;
			end else if (adv) begin
				if (fin) begin
					busy_q <= 1'b0;
				end
				tm_q <= tm_q + 1'b1;
				if (bit_q == 4'd8) begin
					bit_q <= '0;
					if (byte_q) begin
						tail_q <= 1'b1;
					end else begin
						byte_q <= 1'b1;
					end
				end else begin
					bit_q      <= bit_q + 1'b1;
					cur_q.data <= {cur_q.data[2*ByteW-2:0], 1'b0};
				end
			end
		end
	end

	assign res.valid        = res_valid_q;
	assign res.pulse_long   = res_q.pulse_long;
	assign res.repeat_res   = res_q.repeat_res;
	assign res.low_samples  = res_q.low_samples;
	assign res.high_samples = res_q.high_samples;
	assign res.low_value    = res_q.low_value;
	assign res.high_value   = res_q.high_value;
	assign res.last         = res_q.last;

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (cur_q.kind == CMD_BYTE || cur_q.kind == CMD_CSUM) |-> bit_q <= 4'd8)
		else $error("bit step out of range");

	a_tail_order: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && tail_q |-> cur_q.kind == CMD_CSUM && byte_q && bit_q == 4'd0)
		else $error("final checksum pulse out of order");

endmodule

`default_nettype wire

@@ rtl/core/tape_pulse_width_encoder.sv @@
// Pulse-width tape encoder.
// Requests arrive on req (valid/ready): gap, tapemark, data byte, send
// checksum or clear checksum. Each request turns into a run of results on
// res (valid/ready), one result per pulse or run of identical pulses, with
// last set on the final result of the request.
// Results per request: gap 1 (none for a zero count), tapemark 3 (1 for a
// zero count), data byte 9, send checksum 19, clear checksum none.
// The back end issues one result per cycle unless res.ready stalls it, and
// it takes the next command from the queue as it issues the previous one's
// last result, so results of successive requests follow without a gap.
// A request goes through the queue, cur_q and res_q to its first result.
// A 4-entry command queue sits between the request decoder and the pulse
// sequencer; req.ready drops only while that queue is full.
// When res.ready is low the output register holds its result and the
// sequencer stalls; requests are still taken until the queue fills.
// Configuration (cfg_we, cfg_index, cfg_wdata) must be written while idle.
// Reset restores the default pulse lengths and levels, clears the checksum
// and empties the queue and output register.
`default_nettype none

module tape_pulse_width_encoder import tpwe_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0]    cfg_wdata,
	tpwe_req_if.sink                req,
	tpwe_res_if.source              res
);

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_low   <= LongLowRst;
			cfg_q.long_high  <= LongHighRst;
			cfg_q.short_low  <= ShortLowRst;
			cfg_q.short_high <= ShortHighRst;
			cfg_q.low_level  <= LowLevelRst;
			cfg_q.high_level <= HighLevelRst;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LONG_LOW:   cfg_q.long_low   <= cfg_wdata[LenW-1:0];
				CFG_LONG_HIGH:  cfg_q.long_high  <= cfg_wdata[LenW-1:0];
				CFG_SHORT_LOW:  cfg_q.short_low  <= cfg_wdata[LenW-1:0];
				CFG_SHORT_HIGH: cfg_q.short_high <= cfg_wdata[LenW-1:0];
				CFG_LOW_LEVEL:  cfg_q.low_level  <= cfg_wdata[LevelW-1:0];
				CFG_HIGH_LEVEL: cfg_q.high_level <= cfg_wdata[LevelW-1:0];
				default: begin
				end
			endcase
		end
	end

	tpwe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	tpwe_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	tpwe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.res       (res)
	);

endmodule

`default_nettype wire

@@ dv/tb_tape_pulse_width_encoder.sv @@
`default_nettype none

module tb_tape_pulse_width_encoder;
	import tpwe_pkg::*;

	localparam logic [2:0] REQ_RSVD_LO = 3'd5;
	localparam logic [2:0] REQ_RSVD_HI = 3'd7;
	localparam int         StallLimit  = 4000;
	localparam int         NumRegs     = 6;

	typedef struct packed {
		logic [2:0]        kind;
		logic [CountW-1:0] cnt;
		logic [ByteW-1:0]  b;
		logic              typed;
		logic              has_res;
		res_t              res;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	cfg_idx_t           cfg_index;
	logic [CfgW-1:0]    cfg_wdata;

	tpwe_req_if req_ch ();
	tpwe_res_if res_ch ();

	tape_pulse_width_encoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch.sink),
		.res       (res_ch.source)
	);

	// after reset, default lengths 21/22/11/12, levels 32/224
	dir_row_t dir_tab [21] = '{
		'{REQ_GAP,     16'd1,     8'h00, 1'b1, 1'b1, {1'b0, 16'd1, 6'd11, 6'd12, 8'd32, 8'd224, 1'b1}},
		'{REQ_GAP,     16'd0,     8'hFF, 1'b1, 1'b0, res_t'('0)},
		'{REQ_GAP,     16'hFFFF,  8'hFF, 1'b1, 1'b1,
			{1'b0, 16'hFFFF, 6'd11, 6'd12, 8'd32, 8'd224, 1'b1}},
		'{REQ_TMARK,   16'd0,     8'h00, 1'b1, 1'b1, {1'b1, 16'd2, 6'd21, 6'd22, 8'd32, 8'd224, 1'b1}},
		'{REQ_TMARK,   16'd1,     8'h00, 1'b0, 1'b0, res_t'('0)},
		'{REQ_TMARK,   16'hFFFF,  8'h00, 1'b0, 1'b0, res_t'('0)},
		'{REQ_BYTE,    16'd0,     8'h00, 1'b0, 1'b0, res_t'('0)},
		'{REQ_BYTE,    16'hFFFF,  8'hFF, 1'b0, 1'b0, res_t'('0)},
		'{REQ_BYTE,    16'd0,     8'h80, 1'b0, 1'b0, res_t'('0)},
		'{REQ_BYTE,    16'd0,     8'h01, 1'b0, 1'b0, res_t'('0)},
		'{REQ_BYTE,    16'd0,     8'hA5, 1'b0, 1'b0, res_t'('0)},
		'{REQ_CSUM,    16'd0,     8'h00, 1'b0, 1'b0, res_t'('0)},
		'{REQ_RSVD_LO, 16'hFFFF,  8'hFF, 1'b1, 1'b0, res_t'('0)},
		'{REQ_RSVD_LO + 3'd1, 16'd7, 8'h3C, 1'b1, 1'b0, res_t'('0)},
		'{REQ_RSVD_HI, 16'd0,     8'h00, 1'b1, 1'b0, res_t'('0)},
		'{REQ_CLEAR,   16'hFFFF,  8'hFF, 1'b1, 1'b0, res_t'('0)},
		'{REQ_CSUM,    16'd0,     8'h00, 1'b0, 1'b0, res_t'('0)},
		'{REQ_BYTE,    16'd0,     8'h5A, 1'b0, 1'b0, res_t'('0)},
		'{REQ_CSUM,    16'hFFFF,  8'hFF, 1'b0, 1'b0, res_t'('0)},
		'{REQ_CLEAR,   16'd0,     8'h00, 1'b1, 1'b0, res_t'('0)},
		'{REQ_CSUM,    16'd0,     8'h00, 1'b0, 1'b0, res_t'('0)}
	};

	cfg_t              pw_cfg;
	logic [CountW-1:0] ones_sum;
	res_t              exp_pulses [$];

	logic              row_typed;
	logic              row_has_res;
	res_t              row_res;

	int                src_idle_pct;
	int                rdy_idle_pct;
	int                err_cnt;
	int                n_req;
	int                n_res;
	int                n_settings;
	int                stall_cnt;
	int                q_mark;
	logic              moved;
	res_t              got;
	res_t              want;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic string show_res(res_t r);
		return $sformatf("long=%0d rep=%0d lo_n=%0d hi_n=%0d lo_v=%0d hi_v=%0d last=%0d",
			r.pulse_long, r.repeat_res, r.low_samples, r.high_samples,
			r.low_value, r.high_value, r.last);
	endfunction

	function automatic void push_pulse(logic is_long, logic [CountW-1:0] rep, logic fin);
		res_t r;
		r.pulse_long   = is_long;
		r.repeat_res   = rep;
		r.low_samples  = is_long ? pw_cfg.long_low : pw_cfg.short_low;
		r.high_samples = is_long ? pw_cfg.long_high : pw_cfg.short_high;
		r.low_value    = pw_cfg.low_level;
		r.high_value   = pw_cfg.high_level;
		r.last         = fin;
		exp_pulses.push_back(r);
	endfunction

	// MSB first, then the long stop pulse
	function automatic void push_byte(logic [ByteW-1:0] b, logic stop_last);
		for (int i = ByteW - 1; i >= 0; i--)
			push_pulse(b[i], 16'd1, 1'b0);
		push_pulse(1'b1, 16'd1, stop_last);
	endfunction

	function automatic void encode_request(logic [2:0] kind, logic [CountW-1:0] cnt,
		logic [ByteW-1:0] b);
		case (kind)
			REQ_GAP: begin
				if (cnt != '0)
					push_pulse(1'b0, cnt, 1'b1);
			end
			REQ_TMARK: begin
				if (cnt != '0) begin
					push_pulse(1'b1, cnt, 1'b0);
					push_pulse(1'b0, cnt, 1'b0);
				end
				push_pulse(1'b1, TmarkTailRep, 1'b1);
			end
			REQ_BYTE: begin
				ones_sum = ones_sum + CountW'($countones(b));
				push_byte(b, 1'b1);
			end
			REQ_CSUM: begin
				push_byte(ones_sum[15:8], 1'b0);
				push_byte(ones_sum[7:0], 1'b0);
				push_pulse(1'b1, 16'd1, 1'b1);
			end
			REQ_CLEAR: ones_sum = '0;
			default: ;
		endcase
	endfunction

	task automatic note_fail(string what);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_LONG_LOW:   pw_cfg.long_low   = cfg_wdata[LenW-1:0];
					CFG_LONG_HIGH:  pw_cfg.long_high  = cfg_wdata[LenW-1:0];
					CFG_SHORT_LOW:  pw_cfg.short_low  = cfg_wdata[LenW-1:0];
					CFG_SHORT_HIGH: pw_cfg.short_high = cfg_wdata[LenW-1:0];
					CFG_LOW_LEVEL:  pw_cfg.low_level  = cfg_wdata;
					CFG_HIGH_LEVEL: pw_cfg.high_level = cfg_wdata;
					default: ;
				endcase
			end
			if (req_ch.valid && req_ch.ready) begin
				q_mark = exp_pulses.size();
				encode_request(req_ch.req_type, req_ch.count, req_ch.data_byte);
				if (row_typed) begin
					while (exp_pulses.size() > q_mark)
						void'(exp_pulses.pop_back());
					if (row_has_res)
						exp_pulses.push_back(row_res);
				end
				n_req++;
				moved = 1'b1;
			end
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.pulse_long, res_ch.repeat_res, res_ch.low_samples,
					res_ch.high_samples, res_ch.low_value, res_ch.high_value, res_ch.last};
				n_res++;
				moved = 1'b1;
				if (exp_pulses.size() == 0) begin
					note_fail($sformatf("unexpected pulse: %s", show_res(got)));
				end else begin
					want = exp_pulses.pop_front();
					if (got.pulse_long !== want.pulse_long || got.repeat_res !== want.repeat_res ||
						got.low_samples !== want.low_samples ||
						got.high_samples !== want.high_samples ||
						got.low_value !== want.low_value || got.high_value !== want.high_value ||
						got.last !== want.last)
						note_fail($sformatf("pulse mismatch\n  exp %s\n  got %s",
							show_res(want), show_res(got)));
				end
			end
			stall_cnt = moved ? 0 : stall_cnt + 1;
			if (stall_cnt >= StallLimit) begin
				$display("watchdog: no handshake for %0d cycles, %0d pulses pending",
					StallLimit, exp_pulses.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	always @(negedge clk)
		res_ch.ready <= ($urandom_range(99) >= rdy_idle_pct);

	task automatic send_req(logic [2:0] kind, logic [CountW-1:0] cnt, logic [ByteW-1:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= kind;
		req_ch.count     <= cnt;
		req_ch.data_byte <= b;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// hold off new requests until every pulse is back, then wait out the pipeline
	task automatic drain(int hold);
		req_ch.valid <= 1'b0;
		while (exp_pulses.size() != 0)
			@(negedge clk);
		repeat (hold) @(negedge clk);
	endtask

	task automatic write_regs(logic [CfgW-1:0] vals [NumRegs]);
		cfg_idx_t idx;
		idx = CFG_LONG_LOW;
		for (int i = 0; i < NumRegs; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_wdata <= vals[i];
			@(negedge clk);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
		@(negedge clk);
		n_settings++;
	endtask

	task automatic rand_req();
		int               pick;
		logic [2:0]       kind;
		logic [CountW-1:0] cnt;
		pick = $urandom_range(99);
		if (pick < 15)
			kind = REQ_GAP;
		else if (pick < 30)
			kind = REQ_TMARK;
		else if (pick < 75)
			kind = REQ_BYTE;
		else if (pick < 85)
			kind = REQ_CSUM;
		else if (pick < 93)
			kind = REQ_CLEAR;
		else
			kind = 3'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
		case ($urandom_range(9))
			0:       cnt = '0;
			1, 2:    cnt = CountW'($urandom);
			default: cnt = CountW'($urandom_range(1, 40));
		endcase
		row_typed = 1'b0;
		send_req(kind, cnt, ByteW'($urandom));
	endtask

	initial begin
		logic [CfgW-1:0] regv [NumRegs];
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_LONG_LOW;
		cfg_wdata        = '0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_GAP;
		req_ch.count     = '0;
		req_ch.data_byte = '0;
		res_ch.ready     = 1'b0;
		pw_cfg           = {LongLowRst, LongHighRst, ShortLowRst, ShortHighRst,
			LowLevelRst, HighLevelRst};
		ones_sum         = '0;
		row_typed        = 1'b0;
		row_has_res      = 1'b0;
		row_res          = '0;
		src_idle_pct     = 32;
		rdy_idle_pct     = 32;
		err_cnt          = 0;
		n_req            = 0;
		n_res            = 0;
		n_settings       = 0;
		stall_cnt        = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < $size(dir_tab); i++) begin
			row_typed   = dir_tab[i].typed;
			row_has_res = dir_tab[i].has_res;
			row_res     = dir_tab[i].res;
			send_req(dir_tab[i].kind, dir_tab[i].cnt, dir_tab[i].b);
		end
		row_typed = 1'b0;

		// back-to-back all-ones bytes fill the command queue
		src_idle_pct = 0;
		rdy_idle_pct = 0;
		repeat (16)
			send_req(REQ_BYTE, CountW'($urandom), 8'hFF);
		send_req(REQ_CSUM, '0, '0);

		for (int phase = 0; phase < 5; phase++) begin
			drain(12);
			case (phase)
				0: regv = '{8'h00, 8'hC0, 8'h40, 8'h80, 8'h00, 8'hFF};
				1: regv = '{8'hFF, 8'h3F, 8'hFF, 8'h3F, 8'hFF, 8'h00};
				2: regv = '{8'h01, 8'h01, 8'h01, 8'h01, 8'h55, 8'hAA};
				default: begin
					for (int i = 0; i < NumRegs; i++)
						regv[i] = CfgW'($urandom);
				end
			endcase
			write_regs(regv);
			src_idle_pct = (phase == 1) ? 0 : 32;
			rdy_idle_pct = (phase == 1) ? 0 : 32;
			for (int k = 0; k < 52; k++) begin
				if (k == 26)
					drain(1);
				rand_req();
			end
		end

		drain(20);
		$display("run covered %0d requests and %0d pulse results over %0d register settings,",
			n_req, n_res, n_settings + 1);
		$display("including a full command queue, zero lengths and reserved request types");
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

@@ tape_pulse_width_encoder.f @@
rtl/core/tpwe_pkg.sv
rtl/core/tpwe_if.sv
rtl/core/tpwe_front.sv
rtl/core/tpwe_fifo.sv
rtl/core/tpwe_back.sv
rtl/core/tape_pulse_width_encoder.sv
dv/tb_tape_pulse_width_encoder.sv
